/* rtl/stroke_dab_spacer_macros.svh */
// ----------------------------------------------------------------------------
// stroke_dab_spacer assertion macros
// Wraps concurrent assertions so that synthesis sees nothing.
// ----------------------------------------------------------------------------
`ifndef STROKE_DAB_SPACER_MACROS_SVH
`define STROKE_DAB_SPACER_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define SDS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("stroke_dab_spacer: assertion failed");
// Check that an expression is never true outside reset.
`define SDS_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("stroke_dab_spacer: forbidden condition seen");
`else
`define SDS_ASSERT(lbl, clk, rstn, prop)
`define SDS_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

/* rtl/sds_pkg.sv */
// ----------------------------------------------------------------------------
// sds_pkg
// Widths, register codes, states and controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package sds_pkg;

  localparam int unsigned CoordW     = 24;
  localparam int unsigned PresW      = 13;
  localparam int unsigned RadiusW    = 18;
  localparam int unsigned PerW       = 8;
  localparam int unsigned LenW       = 25;
  localparam int unsigned CarryW     = 24;
  localparam int unsigned TotalW     = 26;
  localparam int unsigned SqW        = 50;
  localparam int unsigned DivNW      = 50;
  localparam int unsigned DivDW      = 26;
  localparam int unsigned MagW       = 24;
  localparam int unsigned PosW       = 25;
  localparam int unsigned DistW      = 25;
  localparam int unsigned LoW        = 12;
  localparam int unsigned HiW        = DistW - LoW;
  localparam int unsigned BaseW      = 25;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 18;
  localparam int unsigned Lanes      = 3;
  localparam int unsigned SqrtSteps  = 25;
  localparam int unsigned MaxDabsDefault = 64;

  localparam logic [PresW-1:0]   FullPressure = 13'd4096;
  localparam logic [RadiusW-1:0] RadiusReset  = 18'd3840;
  localparam logic [PerW-1:0]    PerReset     = 8'd9;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BRUSH_RADIUS    = 2'd0,
    CFG_DABS_PER_RADIUS = 2'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT_START,
    ST_SQRT_WAIT,
    ST_FULL_START,
    ST_FULL_WAIT,
    ST_DIST,
    ST_MULA,
    ST_MULB,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic sq;
    logic sqrt_start;
    logic spc_start;
    logic spc_save;
    logic full_start;
    logic full_save;
    logic dist_calc;
    logic mula;
    logic mulb;
    logic div_start;
    logic interp;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic full_zero;
    logic last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* rtl/sds_div.sv */
// ----------------------------------------------------------------------------
// sds_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sds_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [sds_pkg::DivNW-1:0]   dividend_i,
  input  wire logic [sds_pkg::DivDW-1:0]   divisor_i,
  output logic                             busy_o,
  output logic [sds_pkg::DivNW-1:0]        quotient_o,
  output logic [sds_pkg::DivDW-1:0]        remainder_o
);

  localparam int unsigned CntW = $clog2(sds_pkg::DivNW + 1);
  localparam logic [CntW-1:0] Steps = CntW'(sds_pkg::DivNW);

  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [sds_pkg::DivNW-1:0]   num_q;
  logic [sds_pkg::DivDW-1:0]   rem_q;
  logic [sds_pkg::DivDW-1:0]   den_q;
  logic [sds_pkg::DivDW:0]     trial;
  logic [sds_pkg::DivDW:0]     diff;
  logic                        ge;

  always_comb begin
    trial = {rem_q, num_q[sds_pkg::DivNW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = Steps;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // shift the quotient bits in where the dividend bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[sds_pkg::DivDW-1:0] : trial[sds_pkg::DivDW-1:0];
      num_q <= {num_q[sds_pkg::DivNW-2:0], ge};
    end
  end

  assign busy_o      = cnt_q != '0;
  assign quotient_o  = num_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

/* rtl/sds_dp.sv */
// ----------------------------------------------------------------------------
// sds_dp
// Datapath: input lanes, square root, dividers, dab stepping, output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sds_dp #(
  parameter int unsigned MaxDabs = sds_pkg::MaxDabsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sds_pkg::cmd_t                 cmd_i,
  output sds_pkg::status_t                   status_o,
  input  wire logic                          cfg_valid_i,
  input  wire logic [sds_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [sds_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic [sds_pkg::CoordW-1:0]    start_x_i,
  input  wire logic [sds_pkg::CoordW-1:0]    start_y_i,
  input  wire logic [sds_pkg::CoordW-1:0]    end_x_i,
  input  wire logic [sds_pkg::CoordW-1:0]    end_y_i,
  input  wire logic [sds_pkg::PresW-1:0]     start_pressure_i,
  input  wire logic [sds_pkg::PresW-1:0]     end_pressure_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [sds_pkg::CoordW-1:0]         dab_x_o,
  output logic [sds_pkg::CoordW-1:0]         dab_y_o,
  output logic [sds_pkg::RadiusW-1:0]        dab_size_o,
  output logic                               last_dab_o,
  output logic                               truncated_o
);

  localparam int unsigned CntW = $clog2(MaxDabs + 1);
  localparam int unsigned SqStepW = $clog2(sds_pkg::SqrtSteps + 1);
  localparam logic [sds_pkg::SqW-1:0] SqrtTopBit =
    sds_pkg::SqW'(1) << (2 * (sds_pkg::SqrtSteps - 1));
  localparam int unsigned ProdW = sds_pkg::RadiusW + sds_pkg::PresW + 1;
  localparam int unsigned RoundSh = 12;

  // configuration
  logic [sds_pkg::RadiusW-1:0] radius_q;
  logic [sds_pkg::PerW-1:0]    per_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= sds_pkg::RadiusReset;
      per_q    <= sds_pkg::PerReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sds_pkg::CFG_BRUSH_RADIUS:    radius_q <= cfg_data_i[sds_pkg::RadiusW-1:0];
        sds_pkg::CFG_DABS_PER_RADIUS: per_q    <= cfg_data_i[sds_pkg::PerW-1:0];
        default: ;
      endcase
    end
  end

  // input lanes: x, y, pressure
  logic signed [sds_pkg::BaseW-1:0] lane_a [sds_pkg::Lanes];
  logic signed [sds_pkg::BaseW-1:0] lane_b [sds_pkg::Lanes];
  logic signed [sds_pkg::BaseW-1:0] lane_diff [sds_pkg::Lanes];
  logic [sds_pkg::PresW-1:0]        sp_clamp, ep_clamp;

  always_comb begin
    sp_clamp = (start_pressure_i > sds_pkg::FullPressure) ? sds_pkg::FullPressure
                                                           : start_pressure_i;
    ep_clamp = (end_pressure_i > sds_pkg::FullPressure) ? sds_pkg::FullPressure
                                                         : end_pressure_i;
    lane_a[0] = {start_x_i[sds_pkg::CoordW-1], start_x_i};
    lane_b[0] = {end_x_i[sds_pkg::CoordW-1], end_x_i};
    lane_a[1] = {start_y_i[sds_pkg::CoordW-1], start_y_i};
    lane_b[1] = {end_y_i[sds_pkg::CoordW-1], end_y_i};
    lane_a[2] = {{(sds_pkg::BaseW - sds_pkg::PresW){1'b0}}, sp_clamp};
    lane_b[2] = {{(sds_pkg::BaseW - sds_pkg::PresW){1'b0}}, ep_clamp};
    for (int i = 0; i < sds_pkg::Lanes; i++) begin
      lane_diff[i] = lane_b[i] - lane_a[i];
    end
  end

  logic signed [sds_pkg::BaseW-1:0] base_q [sds_pkg::Lanes];
  logic [sds_pkg::MagW-1:0]         mag_q  [sds_pkg::Lanes];
  logic                             neg_q  [sds_pkg::Lanes];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < sds_pkg::Lanes; i++) begin
        base_q[i] <= lane_a[i];
        neg_q[i]  <= lane_diff[i][sds_pkg::BaseW-1];
        mag_q[i]  <= lane_diff[i][sds_pkg::BaseW-1]
                     ? sds_pkg::MagW'(-lane_diff[i]) : sds_pkg::MagW'(lane_diff[i]);
      end
    end
  end

  // squares of the deltas
  logic [2*sds_pkg::MagW-1:0] sqx_q, sqy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq) begin
      sqx_q <= mag_q[0] * mag_q[0];
      sqy_q <= mag_q[1] * mag_q[1];
    end
  end

  // square root, two radicand bits per step
  logic [sds_pkg::SqW-1:0] sv_q, sr_q, sbit_q, s_sum;
  logic [SqStepW-1:0]      scnt_q;
  logic [sds_pkg::LenW-1:0] len;

  assign s_sum = sr_q + sbit_q;
  assign len   = sr_q[sds_pkg::LenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scnt_q <= '0;
    end else if (cmd_i.sqrt_start) begin
      scnt_q <= SqStepW'(sds_pkg::SqrtSteps);
    end else if (scnt_q != '0) begin
      scnt_q <= scnt_q - SqStepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sv_q   <= sds_pkg::SqW'(sqx_q) + sds_pkg::SqW'(sqy_q);
      sr_q   <= '0;
      sbit_q <= SqrtTopBit;
    end else if (scnt_q != '0) begin
      if (sv_q >= s_sum) begin
        sv_q <= sv_q - s_sum;
        sr_q <= (sr_q >> 1) + sbit_q;
      end else begin
        sr_q <= sr_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  // dividers: lane 0 also serves spacing and dab count
  logic [sds_pkg::DivNW-1:0] div_num   [sds_pkg::Lanes];
  logic [sds_pkg::DivDW-1:0] div_den   [sds_pkg::Lanes];
  logic                      div_start [sds_pkg::Lanes];
  logic                      div_busy  [sds_pkg::Lanes];
  logic [sds_pkg::DivNW-1:0] div_quo   [sds_pkg::Lanes];
  logic [sds_pkg::DivDW-1:0] div_rem   [sds_pkg::Lanes];
  logic [sds_pkg::DivNW-1:0] num_q     [sds_pkg::Lanes];

  logic [sds_pkg::RadiusW-1:0] spacing_q;
  logic [sds_pkg::CarryW-1:0]  carry_q, seg_carry_q;
  logic [sds_pkg::TotalW-1:0]  total_q;
  logic [sds_pkg::PerW-1:0]    per_eff;

  assign per_eff = (per_q == '0) ? sds_pkg::PerW'(1) : per_q;

  always_comb begin
    for (int i = 0; i < sds_pkg::Lanes; i++) begin
      div_num[i]   = num_q[i];
      div_den[i]   = sds_pkg::DivDW'(len);
      div_start[i] = cmd_i.div_start;
    end
    if (cmd_i.spc_start) begin
      div_num[0]   = sds_pkg::DivNW'(radius_q);
      div_den[0]   = sds_pkg::DivDW'(per_eff);
      div_start[0] = 1'b1;
    end else if (cmd_i.full_start) begin
      div_num[0]   = sds_pkg::DivNW'(sds_pkg::TotalW'(len) + sds_pkg::TotalW'(carry_q));
      div_den[0]   = sds_pkg::DivDW'(spacing_q);
      div_start[0] = 1'b1;
    end
  end

  for (genvar g = 0; g < sds_pkg::Lanes; g++) begin : g_div
    sds_div u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .start_i     (div_start[g]),
      .dividend_i  (div_num[g]),
      .divisor_i   (div_den[g]),
      .busy_o      (div_busy[g]),
      .quotient_o  (div_quo[g]),
      .remainder_o (div_rem[g])
    );
  end

  // segment bookkeeping
  logic [sds_pkg::TotalW-1:0] full;
  logic                       full_trunc;
  logic [CntW-1:0]            n_q, k_q;
  logic                       trunc_q;
  logic [sds_pkg::PosW-1:0]   pos_q;

  assign full       = div_quo[0][sds_pkg::TotalW-1:0];
  assign full_trunc = full > sds_pkg::TotalW'(MaxDabs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else if (cmd_i.full_save) begin
      if (full == '0) begin
        carry_q <= total_q[sds_pkg::CarryW-1:0];
      end else if (full_trunc) begin
        carry_q <= '0;
      end else begin
        carry_q <= div_rem[0][sds_pkg::CarryW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.spc_save) begin
      spacing_q <= (div_quo[0][sds_pkg::RadiusW-1:0] == '0)
                   ? sds_pkg::RadiusW'(1) : div_quo[0][sds_pkg::RadiusW-1:0];
    end
    if (cmd_i.full_start) begin
      total_q <= sds_pkg::TotalW'(len) + sds_pkg::TotalW'(carry_q);
    end
    if (cmd_i.full_save) begin
      seg_carry_q <= carry_q;
      trunc_q     <= full_trunc;
      n_q         <= full_trunc ? CntW'(MaxDabs) : full[CntW-1:0];
      k_q         <= '0;
      pos_q       <= sds_pkg::PosW'(spacing_q);
    end else if (cmd_i.emit) begin
      k_q   <= k_q + CntW'(1);
      pos_q <= pos_q + sds_pkg::PosW'(spacing_q);
    end
  end

  // per-dab distance, products and numerators
  logic [sds_pkg::PosW-1:0]  dist_raw;
  logic [sds_pkg::DistW-1:0] dist_q;
  logic [sds_pkg::MagW+sds_pkg::LoW-1:0] plo_q [sds_pkg::Lanes];
  logic [sds_pkg::MagW+sds_pkg::HiW-1:0] phi_q [sds_pkg::Lanes];
  logic signed [sds_pkg::BaseW-1:0] res_q [sds_pkg::Lanes];
  logic signed [sds_pkg::BaseW-1:0] qext  [sds_pkg::Lanes];

  assign dist_raw = (pos_q > sds_pkg::PosW'(seg_carry_q))
                    ? pos_q - sds_pkg::PosW'(seg_carry_q) : '0;

  always_comb begin
    for (int i = 0; i < sds_pkg::Lanes; i++) begin
      qext[i] = (len == '0) ? '0
                : signed'({1'b0, div_quo[i][sds_pkg::MagW-1:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dist_calc) begin
      dist_q <= (dist_raw > sds_pkg::PosW'(len)) ? sds_pkg::DistW'(len)
                                                 : sds_pkg::DistW'(dist_raw);
    end
    for (int i = 0; i < sds_pkg::Lanes; i++) begin
      if (cmd_i.mula) begin
        plo_q[i] <= mag_q[i] * dist_q[sds_pkg::LoW-1:0];
        phi_q[i] <= mag_q[i] * dist_q[sds_pkg::DistW-1:sds_pkg::LoW];
      end
      if (cmd_i.mulb) begin
        num_q[i] <= (sds_pkg::DivNW'(phi_q[i]) << sds_pkg::LoW)
                    + sds_pkg::DivNW'(plo_q[i])
                    + sds_pkg::DivNW'(len >> 1);
      end
      if (cmd_i.interp) begin
        res_q[i] <= neg_q[i] ? base_q[i] - qext[i] : base_q[i] + qext[i];
      end
    end
  end

  // output beat
  logic [ProdW-1:0] size_sum;
  logic             out_valid_q;

  assign size_sum = ProdW'(radius_q) * ProdW'(res_q[2][sds_pkg::PresW-1:0])
                    + (ProdW'(1) << (RoundSh - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      dab_x_o     <= res_q[0][sds_pkg::CoordW-1:0];
      dab_y_o     <= res_q[1][sds_pkg::CoordW-1:0];
      dab_size_o  <= size_sum[RoundSh +: sds_pkg::RadiusW];
      last_dab_o  <= (k_q + CntW'(1)) == n_q;
      truncated_o <= trunc_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.busy      = (scnt_q != '0) || div_busy[0] || div_busy[1] || div_busy[2];
  assign status_o.full_zero = full == '0;
  assign status_o.last      = (k_q + CntW'(1)) == n_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

/* rtl/sds_ctrl.sv */
// ----------------------------------------------------------------------------
// sds_ctrl
// Sequencer: segment setup, then one pass per dab.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stroke_dab_spacer_macros.svh"

module sds_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sds_pkg::status_t  status_i,
  output sds_pkg::cmd_t          cmd_o
);

  sds_pkg::state_e state_q, state_d;
  logic            unit_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sds_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sds_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sds_pkg::ST_SQ;
        end
      end
      sds_pkg::ST_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = sds_pkg::ST_SQRT_START;
      end
      sds_pkg::ST_SQRT_START: begin
        cmd_o.sqrt_start = 1'b1;
        cmd_o.spc_start  = 1'b1;
        state_d          = sds_pkg::ST_SQRT_WAIT;
      end
      sds_pkg::ST_SQRT_WAIT: begin
        if (!status_i.busy) begin
          cmd_o.spc_save = 1'b1;
          state_d        = sds_pkg::ST_FULL_START;
        end
      end
      sds_pkg::ST_FULL_START: begin
        cmd_o.full_start = 1'b1;
        state_d          = sds_pkg::ST_FULL_WAIT;
      end
      sds_pkg::ST_FULL_WAIT: begin
        if (!status_i.busy) begin
          cmd_o.full_save = 1'b1;
          state_d = status_i.full_zero ? sds_pkg::ST_IDLE : sds_pkg::ST_DIST;
        end
      end
      sds_pkg::ST_DIST: begin
        cmd_o.dist_calc = 1'b1;
        state_d         = sds_pkg::ST_MULA;
      end
      sds_pkg::ST_MULA: begin
        cmd_o.mula = 1'b1;
        state_d    = sds_pkg::ST_MULB;
      end
      sds_pkg::ST_MULB: begin
        cmd_o.mulb = 1'b1;
        state_d    = sds_pkg::ST_DIV_START;
      end
      sds_pkg::ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = sds_pkg::ST_DIV_WAIT;
      end
      sds_pkg::ST_DIV_WAIT: begin
        if (!status_i.busy) begin
          cmd_o.interp = 1'b1;
          state_d      = sds_pkg::ST_EMIT;
        end
      end
      sds_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.last ? sds_pkg::ST_IDLE : sds_pkg::ST_DIST;
        end
      end
      default: begin
        state_d = sds_pkg::ST_IDLE;
      end
    endcase
  end

  assign unit_start = cmd_o.div_start || cmd_o.full_start || cmd_o.spc_start;

  `SDS_ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, unit_start && status_i.busy)
  `SDS_ASSERT(a_idle_units_quiet, clk_i, rst_ni, (state_q == sds_pkg::ST_IDLE) |-> !status_i.busy)
  `SDS_ASSERT(a_emit_has_room, clk_i, rst_ni, cmd_o.emit |-> status_i.out_free)
  `SDS_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, cmd_o.load |=> (state_q == sds_pkg::ST_SQ))

endmodule

`default_nettype wire

/* rtl/stroke_dab_spacer.sv */
// Run time is set by the 50-step restoring divider: spacing, dab count and the
// three interpolations each take one pass; the 25-step square root runs alongside.
// A segment holds the input until all of its dabs have been emitted.
// Reset: asynchronous, active low; clears the carried distance and loads the register
// defaults (radius 15.0 px, 9 dabs per radius). No clearing pass is needed.
// ----------------------------------------------------------------------------
// stroke_dab_spacer
// Places brush dabs evenly along pen stroke segments, carrying the leftover
// distance from one segment to the next.
// ----------------------------------------------------------------------------
`default_nettype none

module stroke_dab_spacer #(
  parameter int unsigned MAX_DABS_PER_SEGMENT = sds_pkg::MaxDabsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // register write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sds_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [sds_pkg::CfgDataW-1:0]  cfg_data_i,
  // segment channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [sds_pkg::CoordW-1:0]    start_x_i,
  input  wire logic [sds_pkg::CoordW-1:0]    start_y_i,
  input  wire logic [sds_pkg::CoordW-1:0]    end_x_i,
  input  wire logic [sds_pkg::CoordW-1:0]    end_y_i,
  input  wire logic [sds_pkg::PresW-1:0]     start_pressure_i,
  input  wire logic [sds_pkg::PresW-1:0]     end_pressure_i,
  // dab channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [sds_pkg::CoordW-1:0]         dab_x_o,
  output logic [sds_pkg::CoordW-1:0]         dab_y_o,
  output logic [sds_pkg::RadiusW-1:0]        dab_size_o,
  output logic                               last_dab_o,
  output logic                               truncated_o
);

  sds_pkg::cmd_t    cmd;
  sds_pkg::status_t status;

  // User must change registers only between segments (unenforced); no write stalls.
  assign cfg_ready_o = 1'b1;

  // Sequencer: walks setup (square, root, spacing, count) and then each dab.
  sds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: holds the segment, the carry and the output beat register, so the
  // next segment can be taken while the last dab still waits downstream.
  sds_dp #(
    .MaxDabs (MAX_DABS_PER_SEGMENT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .end_x_i          (end_x_i),
    .end_y_i          (end_y_i),
    .start_pressure_i (start_pressure_i),
    .end_pressure_i   (end_pressure_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .dab_x_o          (dab_x_o),
    .dab_y_o          (dab_y_o),
    .dab_size_o       (dab_size_o),
    .last_dab_o       (last_dab_o),
    .truncated_o      (truncated_o)
  );

endmodule

`default_nettype wire
